FILE: hdl/page_frame_chain_allocator_assert.svh
// Assertion macros for the page frame chain allocator.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef PAGE_FRAME_CHAIN_ALLOCATOR_ASSERT_SVH
`define PAGE_FRAME_CHAIN_ALLOCATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFCA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFCA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/pfca_pkg.sv
`timescale 1ns / 1ps

package pfca_pkg;

  localparam int NUM_FRAMES   = 1024;
  localparam int PAGE_BYTES   = 1024;
  localparam int VSPACE_BYTES = 1048576;

  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int OWNER_W    = 16;
  localparam int ADDR_W     = 21;
  localparam int LINK_W     = 11;
  localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
  localparam int PAGES_W    = ADDR_W - PAGE_SHIFT + 1;
  localparam int SUM_W      = ADDR_W + 2;

  localparam logic [LINK_W-1:0] LINK_END = '1;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } pfca_op_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_VSHORT  = 2'd1,
    STAT_NOFRAME = 2'd2,
    STAT_UNOWNED = 2'd3
  } pfca_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic         load;
    logic         clr;
    logic         scan;
    logic         tail;
    logic         walk_rd;
    logic         walk_clr;
    logic         emit;
    pfca_status_t code;
  } pfca_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic clr_last;
    logic vshort;
    logic frames_short;
    logic zero_pages;
    logic scan_last;
    logic walk_owned;
    logic walk_first;
    logic walk_stop;
  } pfca_sts_t;

endpackage

FILE: hdl/pfca_ctrl.sv
`timescale 1ns / 1ps

module pfca_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_command,
  input  pfca_pkg::pfca_sts_t sts,
  output pfca_pkg::pfca_cmd_t cmd,
  output logic                busy,
  output logic                out_valid
);
  import pfca_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ACHK,
    S_ASCAN,
    S_ATAIL,
    S_WALK_RD,
    S_WALK_ST
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;
  logic   out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.code  = STAT_OK;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = (in_command == OP_FREE) ? S_WALK_RD : S_ACHK;
        end
      end
      S_ACHK: begin
        if (sts.vshort) begin
          cmd.emit  = 1'b1;
          cmd.code  = STAT_VSHORT;
          state_nxt = S_IDLE;
        end else if (sts.frames_short) begin
          cmd.emit  = 1'b1;
          cmd.code  = STAT_NOFRAME;
          state_nxt = S_IDLE;
        end else if (sts.zero_pages) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_ASCAN;
        end
      end
      S_ASCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_ATAIL;
        end
      end
      S_ATAIL: begin
        cmd.tail  = 1'b1;
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_WALK_RD: begin
        cmd.walk_rd = 1'b1;
        state_nxt   = S_WALK_ST;
      end
      S_WALK_ST: begin
        if (!sts.walk_owned) begin
          cmd.emit  = 1'b1;
          cmd.code  = sts.walk_first ? STAT_UNOWNED : STAT_OK;
          state_nxt = S_IDLE;
        end else begin
          cmd.walk_clr = 1'b1;
          if (sts.walk_stop) begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_WALK_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      busy_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      busy_r      <= (state_nxt != S_IDLE);
      out_valid_r <= cmd.emit;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;

endmodule

FILE: hdl/pfca_dp.sv
`timescale 1ns / 1ps

module pfca_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pfca_pkg::pfca_cmd_t                  cmd,
  output pfca_pkg::pfca_sts_t                  sts,
  input  logic                                 in_command,
  input  logic [pfca_pkg::OWNER_W-1:0]         in_owner_id,
  input  logic [pfca_pkg::ADDR_W-1:0]          in_alloc_bytes,
  input  logic [pfca_pkg::ADDR_W-1:0]          in_break_pointer,
  input  logic [pfca_pkg::FRAME_W-1:0]         in_start_frame,
  output logic [1:0]                           out_status,
  output logic [pfca_pkg::ADDR_W-1:0]          out_virtual_base,
  output logic [pfca_pkg::ADDR_W-1:0]          out_new_break_pointer,
  output logic [pfca_pkg::FRAME_W-1:0]         out_first_frame,
  output logic [pfca_pkg::CNT_W-1:0]           out_frames_released
);
  import pfca_pkg::*;

  // Per-frame records.
  logic [OWNER_W-1:0] owner_mem [NUM_FRAMES];
  logic [FRAME_W-1:0] pos_mem   [NUM_FRAMES];
  logic [LINK_W-1:0]  link_mem  [NUM_FRAMES];

  // Latched command.
  logic               op_r;
  logic [OWNER_W-1:0] owner_r;
  logic [ADDR_W-1:0]  bp_r;
  logic [ADDR_W-1:0]  end_bp_r;
  logic [PAGES_W-1:0] pages_r;
  logic               vshort_r;

  // Control state.
  logic [CNT_W-1:0]   free_cnt_r;
  logic [FRAME_W-1:0] clr_idx_r;
  logic [FRAME_W-1:0] scan_r;
  logic               rd_vld_r;
  logic [FRAME_W-1:0] rd_idx_r;
  logic [CNT_W-1:0]   found_r;
  logic [FRAME_W-1:0] prev_r;
  logic [FRAME_W-1:0] first_r;
  logic [FRAME_W-1:0] cur_r;
  logic [CNT_W-1:0]   cnt_r;

  // Registered read data.
  logic [OWNER_W-1:0] owner_q;
  logic [LINK_W-1:0]  link_q;

  // Result registers.
  logic [1:0]         stat_out_r;
  logic [ADDR_W-1:0]  vbase_out_r;
  logic [ADDR_W-1:0]  nbp_out_r;
  logic [FRAME_W-1:0] first_out_r;
  logic [CNT_W-1:0]   rel_out_r;

  logic [PAGES_W-1:0]            pages_in;
  logic [PAGES_W+PAGE_SHIFT-1:0] need_in;
  logic [SUM_W-1:0]              end_sum;
  logic [FRAME_W-1:0]            rd_addr;
  logic                          hit;
  logic [CNT_W-1:0]              found_inc;
  logic [CNT_W-1:0]              released;
  logic                          alloc_ok;

  logic               own_we;
  logic [FRAME_W-1:0] own_addr;
  logic [OWNER_W-1:0] own_wdata;
  logic [FRAME_W-1:0] pos_wdata;
  logic               link_we;
  logic [FRAME_W-1:0] link_addr;
  logic [LINK_W-1:0]  link_wdata;

  // Page rounding feeds one add of the break pointer for the virtual space check.
  assign pages_in = {1'b0, in_alloc_bytes[ADDR_W-1:PAGE_SHIFT]}
                    + PAGES_W'(|in_alloc_bytes[PAGE_SHIFT-1:0]);
  assign need_in  = {pages_in, {PAGE_SHIFT{1'b0}}};
  assign end_sum  = SUM_W'(in_break_pointer) + SUM_W'(need_in);

  assign rd_addr   = cmd.walk_rd ? cur_r : scan_r;
  assign hit       = cmd.scan && rd_vld_r && (owner_q == '0);
  assign found_inc = found_r + CNT_W'(1);
  assign released  = cmd.walk_clr ? (cnt_r + CNT_W'(1)) : cnt_r;
  assign alloc_ok  = (op_r == OP_ALLOC) && (cmd.code == STAT_OK);

  always_comb begin
    sts              = '0;
    sts.clr_last     = (clr_idx_r == FRAME_W'(NUM_FRAMES - 1));
    sts.vshort       = vshort_r;
    sts.frames_short = (free_cnt_r == '0) || (pages_r > PAGES_W'(free_cnt_r));
    sts.zero_pages   = (pages_r == '0);
    sts.scan_last    = hit && (PAGES_W'(found_inc) == pages_r);
    sts.walk_owned   = (owner_q != '0);
    sts.walk_first   = (cnt_r == '0);
    sts.walk_stop    = (link_q >= LINK_W'(NUM_FRAMES))
                       || (cnt_r == CNT_W'(NUM_FRAMES - 1));
  end

  // Write port selection for the owner and position records.
  always_comb begin
    own_we    = 1'b0;
    own_addr  = rd_idx_r;
    own_wdata = '0;
    pos_wdata = '0;
    if (cmd.clr) begin
      own_we   = 1'b1;
      own_addr = clr_idx_r;
    end else if (hit) begin
      own_we    = 1'b1;
      own_wdata = owner_r;
      pos_wdata = found_r[FRAME_W-1:0];
    end else if (cmd.walk_clr) begin
      own_we   = 1'b1;
      own_addr = cur_r;
    end
  end

  // Write port selection for the link records.
  always_comb begin
    link_we    = 1'b0;
    link_addr  = prev_r;
    link_wdata = '0;
    if (cmd.clr) begin
      link_we   = 1'b1;
      link_addr = clr_idx_r;
    end else if (hit && (found_r != '0)) begin
      link_we    = 1'b1;
      link_wdata = LINK_W'(rd_idx_r);
    end else if (cmd.tail) begin
      link_we    = 1'b1;
      link_wdata = LINK_END;
    end else if (cmd.walk_clr) begin
      link_we   = 1'b1;
      link_addr = cur_r;
    end
  end

  always_ff @(posedge clk) begin
    if (own_we) begin
      owner_mem[own_addr] <= own_wdata;
      pos_mem[own_addr]   <= pos_wdata;
    end
    owner_q <= owner_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_addr] <= link_wdata;
    end
    link_q <= link_mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_cnt_r <= CNT_W'(NUM_FRAMES);
      clr_idx_r  <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.clr) begin
        clr_idx_r <= clr_idx_r + FRAME_W'(1);
      end
      if (cmd.tail && (owner_r != '0)) begin
        free_cnt_r <= free_cnt_r - pages_r[CNT_W-1:0];
      end else if (cmd.walk_clr) begin
        free_cnt_r <= free_cnt_r + CNT_W'(1);
      end
    end
  end

  // Command latch and walking registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_command;
      owner_r  <= in_owner_id;
      bp_r     <= in_break_pointer;
      end_bp_r <= end_sum[ADDR_W-1:0];
      pages_r  <= pages_in;
      vshort_r <= (end_sum > SUM_W'(VSPACE_BYTES));
      cur_r    <= in_start_frame;
      cnt_r    <= '0;
      found_r  <= '0;
      first_r  <= '0;
      scan_r   <= '0;
    end else begin
      if (cmd.scan) begin
        scan_r   <= scan_r + FRAME_W'(1);
        rd_idx_r <= scan_r;
      end
      if (hit) begin
        found_r <= found_inc;
        prev_r  <= rd_idx_r;
        if (found_r == '0) begin
          first_r <= rd_idx_r;
        end
      end
      if (cmd.walk_clr) begin
        cnt_r <= cnt_r + CNT_W'(1);
        cur_r <= link_q[FRAME_W-1:0];
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      stat_out_r  <= cmd.code;
      vbase_out_r <= alloc_ok ? bp_r : '0;
      nbp_out_r   <= alloc_ok ? end_bp_r : bp_r;
      first_out_r <= alloc_ok ? first_r : '0;
      rel_out_r   <= released;
    end
  end

  assign out_status            = stat_out_r;
  assign out_virtual_base      = vbase_out_r;
  assign out_new_break_pointer = nbp_out_r;
  assign out_first_frame       = first_out_r;
  assign out_frames_released   = rel_out_r;

endmodule

FILE: hdl/page_frame_chain_allocator.sv
`timescale 1ns / 1ps
// Physical page frame allocator with chained frame records. Pulse start while
// busy is low to issue a transaction; the result appears for exactly one cycle
// with out_valid high and cannot be held off, so capture it on that cycle.
// After reset the block sweeps all 1024 frame records to free, one per cycle,
// and holds busy high throughout the sweep. An allocate ends after its check
// when it fails or asks for zero bytes; otherwise it scans the owner memory one
// frame per cycle, reads each frame through a registered port, then marks the
// chain end in a tail state and registers the result strobe.
// A free alternates a link read state and a check-and-clear state per frame of
// the chain, since each link read must see the previous frame's clear. When the
// walk has to read an unowned frame to stop, which includes a refused start
// frame, it reads and checks that frame as well before it stops.

module page_frame_chain_allocator (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_command,
  input  logic [pfca_pkg::OWNER_W-1:0] in_owner_id,
  input  logic [pfca_pkg::ADDR_W-1:0]  in_alloc_bytes,
  input  logic [pfca_pkg::ADDR_W-1:0]  in_break_pointer,
  input  logic [pfca_pkg::FRAME_W-1:0] in_start_frame,
  output logic                         out_valid,
  output logic [1:0]                   out_status,
  output logic [pfca_pkg::ADDR_W-1:0]  out_virtual_base,
  output logic [pfca_pkg::ADDR_W-1:0]  out_new_break_pointer,
  output logic [pfca_pkg::FRAME_W-1:0] out_first_frame,
  output logic [pfca_pkg::CNT_W-1:0]   out_frames_released
);
  import pfca_pkg::*;

  `include "page_frame_chain_allocator_assert.svh"

  pfca_cmd_t cmd;
  pfca_sts_t sts;

  // The controller sequences the clearing sweep, the allocate scan and the
  // free walk; the datapath holds the frame records and the counters.
  pfca_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .sts        (sts),
    .cmd        (cmd),
    .busy       (busy),
    .out_valid  (out_valid)
  );

  pfca_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_command            (in_command),
    .in_owner_id           (in_owner_id),
    .in_alloc_bytes        (in_alloc_bytes),
    .in_break_pointer      (in_break_pointer),
    .in_start_frame        (in_start_frame),
    .out_status            (out_status),
    .out_virtual_base      (out_virtual_base),
    .out_new_break_pointer (out_new_break_pointer),
    .out_first_frame       (out_first_frame),
    .out_frames_released   (out_frames_released)
  );

  // An accepted transaction always raises busy.
  `PFCA_ASSERT_NXT(a_accept_busy, start && !busy, busy, "accepted transaction left block idle")

  // Every transaction passes through a working state after its start, so results
  // never come in consecutive cycles.
  `PFCA_ASSERT_NXT(a_single_strobe, out_valid, !out_valid, "result strobe held two cycles")

  // A result is only produced when the transaction is complete.
  `PFCA_ASSERT_IMP(a_done_idle, out_valid, !busy, "result shown while still busy")

  // A failed transaction returns no region, no frame and no released count.
  `PFCA_ASSERT_IMP(a_fail_clean, out_valid && (out_status != STAT_OK),
    (out_virtual_base == '0) && (out_first_frame == '0) && (out_frames_released == '0),
    "failed transaction returned nonzero fields")

endmodule

FILE: dv/page_frame_chain_allocator_tb.sv
`timescale 1ns / 1ps

module page_frame_chain_allocator_tb;
  import pfca_pkg::*;

  // A free of a chain that spans every frame is the slowest transaction, and the
  // reset sweep of the frame records also keeps the block busy. The stall limit
  // covers both with a wide margin.
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 2 * NUM_FRAMES + 64;
  localparam int RANDOM_ITEMS = 560;

  // One result transaction as it should appear on the out_ ports.
  typedef struct packed {
    pfca_status_t         status;
    logic [ADDR_W-1:0]    virtual_base;
    logic [ADDR_W-1:0]    new_break_pointer;
    logic [FRAME_W-1:0]   first_frame;
    logic [CNT_W-1:0]     frames_released;
  } frame_reply_t;

  // The ledger mirrors the per-frame owner, position and link records. Each
  // accepted command updates the mirror and queues the reply it must produce,
  // and every strobed result is checked against the oldest queued reply.
  class frame_ledger;
    logic [OWNER_W-1:0] owner_of [NUM_FRAMES];
    logic [FRAME_W-1:0] pos_of   [NUM_FRAMES];
    logic [LINK_W-1:0]  link_of  [NUM_FRAMES];
    frame_reply_t       awaited[$];
    int                 mismatches;

    function new();
      for (int i = 0; i < NUM_FRAMES; i++) begin
        owner_of[i] = '0;
        pos_of[i]   = '0;
        link_of[i]  = '0;
      end
      mismatches = 0;
    endfunction

    function int unsigned free_frame_count();
      int unsigned n;
      n = 0;
      for (int i = 0; i < NUM_FRAMES; i++) begin
        if (owner_of[i] == '0) n++;
      end
      return n;
    endfunction

    // The head of a chain is an owned frame at position zero. The search wraps
    // around from a given frame so that heads are picked all over the memory.
    function int find_chain_head(int unsigned from);
      int unsigned idx;
      for (int k = 0; k < NUM_FRAMES; k++) begin
        idx = (from + k) % NUM_FRAMES;
        if (owner_of[idx] != '0 && pos_of[idx] == '0) return idx;
      end
      return -1;
    endfunction

    function void log_command(pfca_op_t op, logic [OWNER_W-1:0] owner,
                              logic [ADDR_W-1:0] bytes, logic [ADDR_W-1:0] bp,
                              logic [FRAME_W-1:0] start_frame);
      frame_reply_t      r;
      int unsigned       pages, need, bp_val, cur, count;
      int unsigned       taken[$];
      logic [LINK_W-1:0] nxt;
      r.status            = STAT_OK;
      r.virtual_base      = '0;
      r.new_break_pointer = bp;
      r.first_frame       = '0;
      r.frames_released   = '0;
      bp_val = bp;
      if (op == OP_ALLOC) begin
        pages = (int'(bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
        need  = pages * PAGE_BYTES;
        // The virtual check comes first, and a break already past the end of
        // the space always counts as short.
        if (bp_val > VSPACE_BYTES || VSPACE_BYTES - bp_val < need) begin
          r.status = STAT_VSHORT;
        end else begin
          // Lowest free frames first. A zero-page request still needs one
          // free frame to exist, although it takes none.
          for (int i = 0; i < NUM_FRAMES; i++) begin
            if (owner_of[i] == '0) begin
              taken.push_back(i);
              if (taken.size() >= pages) break;
            end
          end
          if (taken.size() == 0 || taken.size() < pages) begin
            r.status = STAT_NOFRAME;
          end else begin
            // An owner of zero still writes position and link, but the frames
            // keep reading as free.
            for (int unsigned i = 0; i < pages; i++) begin
              owner_of[taken[i]] = owner;
              pos_of[taken[i]]   = FRAME_W'(i);
              link_of[taken[i]]  = (i + 1 < pages) ? LINK_W'(taken[i + 1]) : LINK_END;
            end
            r.virtual_base      = bp;
            r.new_break_pointer = ADDR_W'(bp_val + need);
            r.first_frame       = (pages > 0) ? FRAME_W'(taken[0]) : '0;
          end
        end
      end else begin
        if (owner_of[start_frame] == '0) begin
          r.status = STAT_UNOWNED;
        end else begin
          // Walk the chain, clearing as we go. The walk ends after the end
          // marker, before a link that leaves the memory or points at a free
          // frame, and in any case after NUM_FRAMES frames.
          cur   = start_frame;
          count = 0;
          while (count < NUM_FRAMES) begin
            nxt = link_of[cur];
            owner_of[cur] = '0;
            pos_of[cur]   = '0;
            link_of[cur]  = '0;
            count++;
            if (nxt == LINK_END || nxt >= NUM_FRAMES || owner_of[nxt] == '0) break;
            cur = nxt;
          end
          r.frames_released = CNT_W'(count);
        end
      end
      awaited.push_back(r);
    endfunction

    function void match_reply(logic [1:0] status, logic [ADDR_W-1:0] vbase,
                              logic [ADDR_W-1:0] nbp, logic [FRAME_W-1:0] ff,
                              logic [CNT_W-1:0] released);
      frame_reply_t exp;
      if (awaited.size() == 0) begin
        $error("result with no command outstanding: status %0d", status);
        mismatches++;
        return;
      end
      exp = awaited.pop_front();
      if (status !== exp.status) begin
        $error("status: expected %0d, got %0d", exp.status, status);
        mismatches++;
      end
      if (vbase !== exp.virtual_base) begin
        $error("virtual_base: expected 0x%0h, got 0x%0h", exp.virtual_base, vbase);
        mismatches++;
      end
      if (nbp !== exp.new_break_pointer) begin
        $error("new_break_pointer: expected 0x%0h, got 0x%0h", exp.new_break_pointer, nbp);
        mismatches++;
      end
      if (ff !== exp.first_frame) begin
        $error("first_frame: expected %0d, got %0d", exp.first_frame, ff);
        mismatches++;
      end
      if (released !== exp.frames_released) begin
        $error("frames_released: expected %0d, got %0d", exp.frames_released, released);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n            = 1'b0;
  logic               start            = 1'b0;
  logic               busy;
  logic               in_command       = 1'b0;
  logic [OWNER_W-1:0] in_owner_id      = '0;
  logic [ADDR_W-1:0]  in_alloc_bytes   = '0;
  logic [ADDR_W-1:0]  in_break_pointer = '0;
  logic [FRAME_W-1:0] in_start_frame   = '0;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [ADDR_W-1:0]  out_virtual_base;
  logic [ADDR_W-1:0]  out_new_break_pointer;
  logic [FRAME_W-1:0] out_first_frame;
  logic [CNT_W-1:0]   out_frames_released;

  frame_ledger ledger = new();
  bit          allow_gaps = 1'b1;
  int unsigned quiet_cycles = 0;

  page_frame_chain_allocator dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_command            (in_command),
    .in_owner_id           (in_owner_id),
    .in_alloc_bytes        (in_alloc_bytes),
    .in_break_pointer      (in_break_pointer),
    .in_start_frame        (in_start_frame),
    .out_valid             (out_valid),
    .out_status            (out_status),
    .out_virtual_base      (out_virtual_base),
    .out_new_break_pointer (out_new_break_pointer),
    .out_first_frame       (out_first_frame),
    .out_frames_released   (out_frames_released)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Issue one command transaction. Now and then start drops for a random gap
  // first, so the gaps land both while the block is still working on the
  // previous command and after it has gone idle. When there is no gap, start
  // simply stays high and only the fields change. The command counts as
  // accepted at the edge where start is high and busy is low, and that is
  // when the ledger sees it.
  task automatic put_command(input pfca_op_t op, input logic [OWNER_W-1:0] owner,
                             input logic [ADDR_W-1:0] bytes,
                             input logic [ADDR_W-1:0] bp,
                             input logic [FRAME_W-1:0] frame);
    if (allow_gaps && $urandom_range(99) < 22) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start            <= 1'b1;
    in_command       <= op;
    in_owner_id      <= owner;
    in_alloc_bytes   <= bytes;
    in_break_pointer <= bp;
    in_start_frame   <= frame;
    do @(posedge clk); while (busy !== 1'b0);
    ledger.log_command(op, owner, bytes, bp, frame);
  endtask

  // The start frame is ignored on an allocate, so it carries random bits.
  task automatic ask_alloc(input logic [OWNER_W-1:0] owner, input logic [ADDR_W-1:0] bytes,
                           input logic [ADDR_W-1:0] bp);
    put_command(OP_ALLOC, owner, bytes, bp, FRAME_W'($urandom()));
  endtask

  // The owner and size are ignored on a free; the break pointer comes back
  // unchanged, so it gets random bits as well.
  task automatic ask_free(input logic [FRAME_W-1:0] frame);
    put_command(OP_FREE, OWNER_W'($urandom()), ADDR_W'($urandom()),
                ADDR_W'($urandom()), frame);
  endtask

  // Results cannot be held off, so every strobed cycle is checked as it comes.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      ledger.match_reply(out_status, out_virtual_base, out_new_break_pointer,
                         out_first_frame, out_frames_released);
    end
  end

  // The stall counter restarts whenever a command or a result moves.
  always @(posedge clk) begin
    if ((rst_n && start && busy === 1'b0) || (rst_n && out_valid === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("page_frame_chain_allocator_tb: FAIL");
    $finish;
  end

  initial begin
    int unsigned        pages, need, roll;
    int                 head;
    logic [ADDR_W-1:0]  bytes, bp;
    logic [OWNER_W-1:0] owner;
    logic [FRAME_W-1:0] frame;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // One edge out of reset, so that busy already shows the record sweep.
    @(posedge clk);

    // Directed part. Small allocations first, one of them with the widest
    // owner and one that rounds a single byte up to a page.
    ask_alloc(16'hFFFF, '0, '0);
    ask_alloc(16'h0001, 21'd1, '0);
    ask_alloc(16'h8000, 21'd1024, 21'd1024);
    ask_alloc(16'h1234, 21'd1025, 21'h2000);
    // A size past the whole space, then a break past the end of it.
    ask_alloc(16'h00FF, 21'h1FFFFF, '0);
    ask_alloc(16'h0F0F, '0, 21'h1FFFFF);
    // A zero-size request right at the end of the space, then a page that
    // ends exactly there.
    ask_alloc(16'h7FFF, '0, ADDR_W'(VSPACE_BYTES));
    ask_alloc(16'h5555, 21'd1024, ADDR_W'(VSPACE_BYTES - 1024));
    // The whole space while a few frames are taken: too few frames.
    ask_alloc(16'h3333, ADDR_W'(VSPACE_BYTES), '0);
    // Free a chain of two, then free it again while it is unowned.
    ask_free(10'd2);
    ask_free(10'd2);
    // Owner zero leaves its frames free; freeing one of them is refused.
    ask_alloc(16'h0000, 21'd3000, 21'h100);
    ask_free(10'd3);
    ask_free(10'd0);
    ask_free(10'd1);
    ask_free(10'd4);
    // Every frame in one chain, then a zero-size request with nothing free.
    ask_alloc(16'hAAAA, ADDR_W'(VSPACE_BYTES), '0);
    ask_alloc(16'h4444, '0, 21'd5);
    // Free the upper half from the middle, then the head, whose walk stops
    // before the link into the half that is already free.
    ask_free(10'd512);
    ask_free(10'd0);
    ask_alloc(16'hCCCC, 21'd3072, '0);
    ask_free(10'd1);
    ask_free(10'd0);
    // A full chain released in one walk.
    ask_alloc(16'h0001, ADDR_W'(VSPACE_BYTES), '0);
    ask_free(10'd0);

    // Random part. Mostly small allocations that fit and frees of real chain
    // heads, with the balance tipped toward frees as the memory fills. The
    // rest is large or fully random sizes and breaks, owner zero, and frees
    // of arbitrary frames.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      allow_gaps = !(n >= 150 && n < 300);
      roll = $urandom_range(99);
      if (roll < ((ledger.free_frame_count() < 256) ? 70 : 35)) begin
        head = ledger.find_chain_head($urandom_range(0, NUM_FRAMES - 1));
        if ($urandom_range(99) < 85 && head >= 0) begin
          frame = FRAME_W'(head);
        end else begin
          frame = FRAME_W'($urandom());
        end
        ask_free(frame);
      end else begin
        roll = $urandom_range(99);
        if (roll < 80) begin
          pages = $urandom_range(0, 6);
          bytes = (pages == 0) ? '0
                               : ADDR_W'(pages * PAGE_BYTES - $urandom_range(0, PAGE_BYTES - 1));
        end else if (roll < 92) begin
          bytes = ADDR_W'($urandom_range(0, VSPACE_BYTES));
        end else begin
          bytes = ADDR_W'($urandom());
        end
        need = ((int'(bytes) + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
        if ($urandom_range(99) < 85 && need <= VSPACE_BYTES) begin
          bp = ADDR_W'($urandom_range(0, VSPACE_BYTES - need));
        end else begin
          bp = ADDR_W'($urandom());
        end
        owner = ($urandom_range(99) < 5) ? '0 : OWNER_W'($urandom_range(1, 65535));
        ask_alloc(owner, bytes, bp);
      end
    end
    start <= 1'b0;

    // Wait for the last reply, then long enough for a stray one to show up.
    while (ledger.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (ledger.mismatches == 0) begin
      $display("page_frame_chain_allocator_tb: PASS");
    end else begin
      $display("page_frame_chain_allocator_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/pfca_pkg.sv
hdl/pfca_ctrl.sv
hdl/pfca_dp.sv
hdl/page_frame_chain_allocator.sv
dv/page_frame_chain_allocator_tb.sv
